>>> sv/pkbrl_pkg.sv
// Shared types and constants of the per-key burst rate limiter.
package pkbrl_pkg;

  // Table geometry
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  // Saturation value of the per-entry message count
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 232;
  localparam int unsigned OutDataW = 8;

  typedef logic [IdxW-1:0] idx_t;

  // One limiter entry as stored in the table RAM
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] window;
    logic [31:0] burst;
    logic [31:0] count;
    logic [63:0] start;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Result status codes
  typedef enum logic [2:0] {
    ST_ALLOWED   = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_NOENTRY   = 3'd2,
    ST_INSTALLED = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_e;

endpackage

>>> sv/pkbrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pkbrl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/per_key_burst_rate_limiter_core.sv
// Top level of the per-key burst rate limiter: key scan sequencer and entry update.
//
//  channel  dir  handshake                        payload
//  s_axis   in   s_axis_tvalid_i/s_axis_tready_o  tdata: key, now_us, address_unreadable,
//                                                 new_window_us, new_burst; tuser: func
//  m_axis   out  m_axis_tvalid_o/m_axis_tready_i  tdata: allow, status
//
// An unreadable-address check message goes straight to the done state. Otherwise
// the walk compares up to TableDepth entries and then checks or writes an entry,
// or goes to the done state when the walk ends with nothing to update. The walk
// runs through the one read port of the table RAM, one entry per cycle.
// Reset clears only the valid bits; no clearing pass, the block is ready at once.
// Results sit in an output register, so the next item is accepted while one waits;
// a finished result waits in its final state until that register frees up.
module per_key_burst_rate_limiter_core
  import pkbrl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [63:0] key, [127:64] now_us, [128] address_unreadable,
  // [192:129] new_window_us, [224:193] new_burst, [231:225] zero
  input  logic [InDataW-1:0] s_axis_tdata_i,
  // [0] func
  input  logic               s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [0] allow, [3:1] status, [7:4] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // Control state
  state_e                state_q, state_d;
  logic [CntW-1:0]       issue_q, issue_d;
  logic                  chk_pend_q, chk_pend_d;
  idx_t                  chk_idx_q, chk_idx_d;
  logic                  free_found_q, free_found_d;
  idx_t                  free_idx_q, free_idx_d;
  idx_t                  slot_q, slot_d;
  logic [TableDepth-1:0] valid_q, valid_d;
  logic                  out_valid_q, out_valid_d;

  // Payload registers
  logic        func_q, func_d;
  logic [63:0] key_q, key_d;
  logic [63:0] now_q, now_d;
  logic [63:0] win_q, win_d;
  logic [31:0] burst_q, burst_d;
  logic        res_allow_q, res_allow_d;
  status_e     res_status_q, res_status_d;
  logic        out_allow_q, out_allow_d;
  status_e     out_status_q, out_status_d;

  // Table RAM port
  logic   ram_re, ram_we;
  idx_t   ram_raddr, ram_waddr;
  entry_t ram_wdata, rd_entry;
  logic [EntryW-1:0] ram_rdata;

  // Input field unpacking
  logic        in_fire, in_unreadable;
  logic [63:0] in_key, in_now, in_win;
  logic [31:0] in_burst;

  assign in_fire       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_key        = s_axis_tdata_i[63:0];
  assign in_now        = s_axis_tdata_i[127:64];
  assign in_unreadable = s_axis_tdata_i[128];
  assign in_win        = s_axis_tdata_i[192:129];
  assign in_burst      = s_axis_tdata_i[224:193];

  assign s_axis_tready_o = (state_q == S_IDLE);

  pkbrl_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Scan compare on the entry read in the previous cycle
  logic match, free_now, last_chk, out_free;

  assign match    = chk_pend_q && valid_q[chk_idx_q] && (rd_entry.key == key_q);
  assign free_now = chk_pend_q && !valid_q[chk_idx_q];
  assign last_chk = chk_pend_q && (chk_idx_q == idx_t'(TableDepth - 1));
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Window check arithmetic on the matched entry
  logic [63:0] elapsed;
  logic [31:0] count_inc;
  logic        new_window;

  assign elapsed    = now_q - rd_entry.start;
  assign count_inc  = rd_entry.count + 32'd1;
  assign new_window = (rd_entry.start == 64'd0) ||
                      ((now_q >= rd_entry.start) && (elapsed > rd_entry.window));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (!s_axis_tuser_i && in_unreadable) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          state_d = S_UPDATE;
        end else if (last_chk) begin
          state_d = (func_q && (free_found_q || free_now)) ? S_UPDATE : S_DONE;
        end
      end
      S_UPDATE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM control and result
  always_comb begin
    issue_d      = issue_q;
    chk_pend_d   = chk_pend_q;
    chk_idx_d    = chk_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    slot_d       = slot_q;
    valid_d      = valid_q;
    func_d       = func_q;
    key_d        = key_q;
    now_d        = now_q;
    win_d        = win_q;
    burst_d      = burst_q;
    res_allow_d  = res_allow_q;
    res_status_d = res_status_q;
    out_allow_d  = out_allow_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    ram_re       = 1'b0;
    ram_raddr    = issue_q[IdxW-1:0];
    ram_we       = 1'b0;
    ram_waddr    = slot_q;
    ram_wdata    = rd_entry;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          func_d       = s_axis_tuser_i;
          key_d        = in_key;
          now_d        = in_now;
          win_d        = in_win;
          burst_d      = in_burst;
          issue_d      = '0;
          chk_pend_d   = 1'b0;
          free_found_d = 1'b0;
          res_allow_d  = 1'b1;
          res_status_d = ST_NOENTRY;
        end
      end

      // One read issued and one entry compared per cycle
      S_SCAN: begin
        ram_re     = (issue_q < CntW'(TableDepth)) && !match;
        issue_d    = ram_re ? (issue_q + CntW'(1)) : issue_q;
        chk_pend_d = ram_re;
        chk_idx_d  = issue_q[IdxW-1:0];
        if (free_now && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = chk_idx_q;
        end
        if (match) begin
          slot_d = chk_idx_q;
        end else if (last_chk) begin
          slot_d = free_found_q ? free_idx_q : chk_idx_q;
          if (func_q) begin
            res_allow_d  = 1'b0;
            res_status_d = ST_FULL;
          end else begin
            res_allow_d  = 1'b1;
            res_status_d = ST_NOENTRY;
          end
        end
      end

      S_UPDATE: begin
        if (func_q) begin
          // Install or replace: all fields written, count and start cleared
          ram_we           = 1'b1;
          ram_wdata.key    = key_q;
          ram_wdata.window = win_q;
          ram_wdata.burst  = burst_q;
          ram_wdata.count  = 32'd0;
          ram_wdata.start  = 64'd0;
          valid_d[slot_q]  = 1'b1;
          res_allow_d      = 1'b0;
          res_status_d     = ST_INSTALLED;
        end else if ((rd_entry.window == 64'd0) || (rd_entry.burst == 32'd0)) begin
          // Limiting disabled for this key
          res_allow_d  = 1'b1;
          res_status_d = ST_ALLOWED;
        end else if (new_window) begin
          ram_we          = 1'b1;
          ram_wdata.start = now_q;
          ram_wdata.count = 32'd1;
          res_allow_d     = 1'b1;
          res_status_d    = ST_ALLOWED;
        end else if (rd_entry.count == CountMax) begin
          // Saturated count stays put
          res_allow_d  = 1'b0;
          res_status_d = ST_BLOCKED;
        end else begin
          ram_we          = 1'b1;
          ram_wdata.count = count_inc;
          if (count_inc <= rd_entry.burst) begin
            res_allow_d  = 1'b1;
            res_status_d = ST_ALLOWED;
          end else begin
            res_allow_d  = 1'b0;
            res_status_d = ST_BLOCKED;
          end
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_allow_d  = res_allow_q;
          out_status_d = res_status_q;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issue_q      <= '0;
      chk_pend_q   <= 1'b0;
      chk_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      slot_q       <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      chk_pend_q   <= chk_pend_d;
      chk_idx_q    <= chk_idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      slot_q       <= slot_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    now_q        <= now_d;
    win_q        <= win_d;
    burst_q      <= burst_d;
    res_allow_q  <= res_allow_d;
    res_status_q <= res_status_d;
    out_allow_q  <= out_allow_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_status_q, out_allow_q};

`ifndef SYNTHESIS
  // Table writes happen only in the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_UPDATE))
    else $error("table write outside update step");

  // The read pointer never runs past the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q <= CntW'(TableDepth))
    else $error("scan pointer beyond table depth");

  // Installed entries never disappear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $past($countones(valid_q)))
    else $error("valid bit lost");

  // Install results never carry allow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_status_q == ST_INSTALLED) || (out_status_q == ST_FULL)))
      |-> !out_allow_q)
    else $error("install result with allow set");

  // An accepted item always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("accepted item not started");
`endif

endmodule
